### hdl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// shared constants, types and sequencer states of the buddy tree allocator
// ----------------------------------------------------------------------------
package bta_pkg;

	// tree shape and block sizes
	localparam int TREE_LEVELS    = 11;
	localparam int MIN_BLOCK_LOG2 = 5;
	localparam int NODE_COUNT     = (1 << TREE_LEVELS) - 1;

	// storage and field widths
	localparam int ADDR_W  = TREE_LEVELS;
	localparam int ORDER_W = $clog2(TREE_LEVELS + 1);
	localparam int DEPTH_W = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
	localparam int POS_W   = (TREE_LEVELS > 1) ? TREE_LEVELS - 1 : 1;
	localparam int REQ_W   = 20;
	localparam int OFF_W   = 15;

	// stream data widths, padded to whole bytes
	localparam int S_TDATA_W = ((REQ_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OFF_W + 7) / 8) * 8;

	// smallest block in bytes
	localparam logic [REQ_W-1:0] MIN_BLOCK_BYTES = REQ_W'(1) << MIN_BLOCK_LOG2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_LEFT,
		ST_RIGHT,
		ST_MARK,
		ST_UP,
		ST_DONE
	} state_t;

	// one allocation result
	typedef struct packed {
		logic             granted;
		logic [OFF_W-1:0] byte_offset;
	} result_t;

endpackage

### hdl/bta_ram.sv
// ----------------------------------------------------------------------------
// bta_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2047
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/bta_unit.sv
// ----------------------------------------------------------------------------
// bta_unit
// shared node unit: fit test on the node just read, and buddy merge of a
// child pair into its parent order
// ----------------------------------------------------------------------------
module bta_unit
	import bta_pkg::*;
(
	input  logic [ORDER_W-1:0] own_order,   // order of the node on the upward path
	input  logic [ORDER_W-1:0] node_order,  // order read from the tree
	input  logic [REQ_W-1:0]   need,
	input  logic [DEPTH_W-1:0] child_depth,
	output logic               fit,
	output logic [ORDER_W-1:0] merged
);

	logic [63:0]        block_bytes;
	logic [ORDER_W-1:0] full_order;

	// block size of the read node against the rounded request
	always_comb begin
		block_bytes = 64'(1) << (7'(node_order) + 7'(MIN_BLOCK_LOG2) - 7'd1);
		fit         = (node_order != '0) && (block_bytes >= 64'(need));
	end

	// two fully free buddies merge, otherwise the larger child wins
	always_comb begin
		full_order = ORDER_W'(TREE_LEVELS - int'(child_depth));
		if (own_order == full_order && node_order == full_order) begin
			merged = full_order + ORDER_W'(1);
		end else if (own_order > node_order) begin
			merged = own_order;
		end else begin
			merged = node_order;
		end
	end

endmodule

### hdl/bta_walk.sv
// ----------------------------------------------------------------------------
// bta_walk
// sequencer of the allocator: clearing pass, descent to the fitting node,
// marking it full and the ancestor update, over one node ram
// ----------------------------------------------------------------------------
module bta_walk
	import bta_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [REQ_W-1:0] req_bytes,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	state_t state_q, state_d;

	logic [REQ_W-1:0]   need_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [DEPTH_W-1:0] dep_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   bit_q;
	logic [ORDER_W-1:0] own_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [DEPTH_W-1:0] lvl_q;
	result_t            res_q;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ORDER_W-1:0] wr_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ORDER_W-1:0] rd_data;

	logic               fit;
	logic [ORDER_W-1:0] merged;

	logic [ADDR_W-1:0]  left_a;
	logic [ADDR_W-1:0]  cand_a;
	logic [ADDR_W-1:0]  cand_left_a;
	logic [ADDR_W-1:0]  sib_a;
	logic [ADDR_W-1:0]  parent_a;
	logic [ADDR_W-1:0]  parent_sib_a;
	logic               more_cand;
	logic               clr_last;
	logic               clr_lvl_end;
	logic [ADDR_W:0]    clr_p1;
	logic [ADDR_W:0]    clr_p2;
	logic [63:0]        off_wide;
	logic               accept;

	assign accept = req_valid && req_ready;

	// node ram
	bta_ram #(
		.WIDTH(ORDER_W),
		.DEPTH(NODE_COUNT)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// shared fit / merge unit
	bta_unit u_unit (
		.own_order  (own_q),
		.node_order (rd_data),
		.need       (need_q),
		.child_depth(dep_q),
		.fit        (fit),
		.merged     (merged)
	);

	// heap address arithmetic
	always_comb begin
		left_a       = (idx_q << 1) + ADDR_W'(1);
		cand_a       = (state_q == ST_RIGHT) ? left_a + ADDR_W'(1) : left_a;
		cand_left_a  = (cand_a << 1) + ADDR_W'(1);
		sib_a        = idx_q[0] ? idx_q + ADDR_W'(1) : idx_q - ADDR_W'(1);
		parent_a     = (idx_q - ADDR_W'(1)) >> 1;
		parent_sib_a = parent_a[0] ? parent_a + ADDR_W'(1) : parent_a - ADDR_W'(1);
		more_cand    = (int'(dep_q) + 2) < TREE_LEVELS;
	end

	// clearing pass bookkeeping
	always_comb begin
		clr_p1      = {1'b0, clr_q} + (ADDR_W+1)'(1);
		clr_p2      = {1'b0, clr_q} + (ADDR_W+1)'(2);
		clr_last    = clr_q == ADDR_W'(NODE_COUNT - 1);
		clr_lvl_end = (clr_p2 & clr_p1) == '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (!fit) state_d = ST_DONE;
				else if (TREE_LEVELS > 1) state_d = ST_LEFT;
				else state_d = ST_MARK;
			end
			ST_LEFT: begin
				if (fit) state_d = more_cand ? ST_LEFT : ST_MARK;
				else state_d = ST_RIGHT;
			end
			ST_RIGHT: begin
				if (fit) state_d = more_cand ? ST_LEFT : ST_MARK;
				else state_d = ST_MARK;
			end
			ST_MARK: begin
				state_d = (idx_q == '0) ? ST_DONE : ST_UP;
			end
			ST_UP: begin
				if (parent_a == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// ram controls and handshake outputs
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = '0;
		rd_addr   = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = ORDER_W'(TREE_LEVELS - int'(lvl_q));
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_addr   = '0;
			end
			ST_ROOT: begin
				rd_addr = left_a;
			end
			ST_LEFT: begin
				rd_addr = fit ? cand_left_a : left_a + ADDR_W'(1);
			end
			ST_RIGHT: begin
				rd_addr = cand_left_a;
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				rd_addr = sib_a;
			end
			ST_UP: begin
				wr_en   = 1'b1;
				wr_addr = parent_a;
				wr_data = merged;
				rd_addr = parent_sib_a;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_p1[ADDR_W-1:0];
				if (clr_lvl_end) lvl_q <= lvl_q + DEPTH_W'(1);
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					need_q <= (req_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : req_bytes;
					idx_q  <= '0;
					dep_q  <= '0;
					pos_q  <= '0;
					bit_q  <= POS_W'(1) << (POS_W - 1);
				end
			end
			ST_ROOT: begin
				if (!fit) begin
					res_q.granted     <= 1'b0;
					res_q.byte_offset <= '0;
				end
			end
			ST_LEFT, ST_RIGHT: begin
				if (fit) begin
					idx_q <= cand_a;
					dep_q <= dep_q + DEPTH_W'(1);
					bit_q <= bit_q >> 1;
					if (state_q == ST_RIGHT) pos_q <= pos_q | bit_q;
				end
			end
			ST_MARK: begin
				own_q             <= '0;
				res_q.granted     <= 1'b1;
				res_q.byte_offset <= off_wide[OFF_W-1:0];
			end
			ST_UP: begin
				own_q <= merged;
				idx_q <= parent_a;
				dep_q <= dep_q - DEPTH_W'(1);
			end
			default: begin
				own_q <= own_q;
			end
		endcase
	end

	// leaf position to byte offset
	assign off_wide = 64'(pos_q) << MIN_BLOCK_LOG2;

	assign res = res_q;

endmodule

### hdl/buddy_tree_allocate.sv
// ----------------------------------------------------------------------------
// buddy_tree_allocate
// buddy allocator over a binary tree of free-block orders held in one ram
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2047 nodes of its eleven
// levels (one tree node per cycle) and takes no request until it ends. Each
// request is then worked one at a time by a sequencer around a single node
// ram with one write and one registered read port. Its steps, in order, are:
//   - take the request
//   - check the root
//   - on the way down, per level, the left child, then the right child when
//     the left one does not fit; the descent may stop above the leaf level
//   - mark the node full
//   - update each level on the way back up
//   - hand the result to the output register
// A request that does not fit ends after the root check. Results sit in an
// output register, so a new request is taken while one waits.
// ----------------------------------------------------------------------------
module buddy_tree_allocate
	import bta_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // request_bytes
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // byte_offset
	output logic                 m_tuser    // granted
);

	logic    res_valid;
	logic    res_ready;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	// allocation sequencer
	bta_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req_bytes(s_tdata[REQ_W-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register, free when empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// payload of the waiting transfer
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.granted;
	assign m_tdata  = M_TDATA_W'(out_q.byte_offset);

endmodule
